[design/seeded_double_matrix_vector_product_defines.svh]
// Assertion macros shared by the seeded double matrix-vector product RTL.
`ifndef SEEDED_DOUBLE_MATRIX_VECTOR_PRODUCT_DEFINES_SVH
`define SEEDED_DOUBLE_MATRIX_VECTOR_PRODUCT_DEFINES_SVH

// Same-cycle implication.
`define SDMVP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SDMVP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/sdmvp_pkg.sv]
// Types, constants and helper functions of the seeded double matrix-vector product.
package sdmvp_pkg;

    localparam int DIM         = 64;
    localparam int IDX_W       = (DIM > 1) ? $clog2(DIM) : 1;
    localparam int ROW_INDEX_W = 6;

    localparam logic [63:0] LCG_MUL  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD  = 64'd1442695040888963407;
    localparam int          FOLD_SHIFT = 5;

    localparam logic [10:0] EXP_LOW  = 11'h5A0;
    localparam logic [10:0] EXP_HIGH = 11'h7FE;
    localparam logic [10:0] EXP_ONE  = 11'h3FF;
    localparam logic [10:0] EXP_ALL  = 11'h7FF;
    localparam logic [12:0] EXP_BIAS = 13'd1023;
    localparam logic [12:0] EXP_OVF  = 13'd2047;
    localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [63:0] DBL_ZERO = 64'h0;

    typedef struct packed {
        logic [7:0] seed_byte;
        logic       seed_last;
    } t_in;

    typedef struct packed {
        logic [63:0]            row_sum_bits;
        logic [ROW_INDEX_W-1:0] row_index;
        logic                   row_last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VLCG,
        S_VWR,
        S_MLCG,
        S_MMUL,
        S_MRND,
        S_AALIGN,
        S_ASUM,
        S_ARND,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic             fold_en;
        logic             fold_load;
        logic             fold_clear;
        logic             lcg_reload;
        logic             lcg_en;
        logic             vec_wr;
        logic             vec_rd;
        logic             mul_en;
        logic             mul_rnd;
        logic             add_align;
        logic             add_sum;
        logic             add_rnd;
        logic             acc_clear;
        logic [1:0]       k;
        logic [IDX_W-1:0] addr;
    } t_cmd;

    // Matrix/vector element from an LCG state.
    function automatic logic [63:0] elem_bits(input logic [63:0] s);
        logic [10:0] e;
        e = s[10:0];
        if (e < EXP_LOW || e > EXP_HIGH) begin
            e = EXP_ONE;
        end
        return {1'b0, e, s[62:11]};
    endfunction

    // Round to nearest even and pack a positive normal value.
    function automatic logic [63:0] rne_pack(input logic [52:0] m, input logic g,
                                             input logic st, input logic [12:0] e);
        logic        inc;
        logic [53:0] r;
        logic [52:0] mm;
        logic [12:0] ee;
        inc = g & (st | m[0]);
        r   = {1'b0, m} + 54'(inc);
        if (r[53]) begin
            mm = r[53:1];
            ee = e + 13'd1;
        end else begin
            mm = r[52:0];
            ee = e;
        end
        if (ee >= EXP_OVF) begin
            return DBL_INF;
        end
        return {1'b0, ee[10:0], mm[51:0]};
    endfunction

endpackage

[design/sdmvp_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module sdmvp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                 i_wr_data,
    input  logic                             i_rd_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                 o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/sdmvp_dpath.sv]
// Datapath: seed fold, LCG, vector RAM, double multiplier and adder.
module sdmvp_dpath (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sdmvp_pkg::t_cmd i_cmd,
    input  logic [7:0]      i_seed_byte,
    output logic [63:0]     o_acc_bits
);
    import sdmvp_pkg::*;

    logic [63:0]  r_fold, n_fold;
    logic [63:0]  r_lcg, n_lcg;
    logic [63:0]  r_acc, n_acc;
    logic [63:0]  r_lcg_acc;
    logic [105:0] r_mul_acc;
    logic [63:0]  r_prod;
    logic         r_pass;
    logic [63:0]  r_pass_bits;
    logic [55:0]  r_big_m;
    logic [55:0]  r_small;
    logic [11:0]  r_big_e;
    logic [55:0]  r_sum_m;
    logic [11:0]  r_sum_e;

    logic [63:0]  w_fold_next;
    logic [15:0]  w_chunk;
    logic [63:0]  w_lcg_term;
    logic [63:0]  w_elem;
    logic [63:0]  w_vec;
    logic [52:0]  w_ma, w_mb;
    logic [26:0]  w_mul_x, w_mul_y;
    logic [53:0]  w_pp;
    logic [105:0] w_mul_term;
    logic [12:0]  w_pexp;
    logic [63:0]  w_prod_bits;
    logic [56:0]  w_sum;

    // Align stage signals
    logic         w_x_inf, w_y_inf, w_x_zero, w_x_ge;
    logic [63:0]  w_big, w_sml;
    logic [10:0]  w_d;
    logic [55:0]  w_sml_ext, w_shift, w_mask, w_align;
    logic         w_sticky;

    assign w_fold_next = (r_fold << FOLD_SHIFT) - r_fold + 64'(i_seed_byte);

    always_comb begin
        w_chunk = r_lcg[15:0];
        case (i_cmd.k)
            2'd0:    w_chunk = r_lcg[15:0];
            2'd1:    w_chunk = r_lcg[31:16];
            2'd2:    w_chunk = r_lcg[47:32];
            2'd3:    w_chunk = r_lcg[63:48];
            default: w_chunk = r_lcg[15:0];
        endcase
        w_lcg_term = (64'(w_chunk) * LCG_MUL) << {i_cmd.k, 4'b0000};
    end

    always_comb begin
        n_fold = r_fold;
        n_lcg  = r_lcg;
        if (i_cmd.fold_en) begin
            n_fold = w_fold_next;
            if (i_cmd.fold_load) begin
                n_lcg = w_fold_next;
            end
        end
        if (i_cmd.fold_clear) begin
            n_fold = '0;
        end
        if (i_cmd.lcg_reload) begin
            n_lcg = r_fold;
        end
        if (i_cmd.lcg_en && i_cmd.k == 2'd3) begin
            n_lcg = r_lcg_acc + w_lcg_term + LCG_ADD;
        end
    end

    assign w_elem = elem_bits(r_lcg);

    sdmvp_ram #(
        .WIDTH (64),
        .DEPTH (DIM)
    ) u_vec_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.vec_wr),
        .i_wr_addr (i_cmd.addr),
        .i_wr_data (w_elem),
        .i_rd_en   (i_cmd.vec_rd),
        .i_rd_addr (i_cmd.addr),
        .o_rd_data (w_vec)
    );

    // Multiplier: four 27x27 partial products
    assign w_ma = {1'b1, w_elem[51:0]};
    assign w_mb = {1'b1, w_vec[51:0]};

    always_comb begin
        w_mul_x    = w_ma[26:0];
        w_mul_y    = w_mb[26:0];
        w_mul_term = '0;
        case (i_cmd.k)
            2'd0: begin
                w_mul_x = w_ma[26:0];
                w_mul_y = w_mb[26:0];
            end
            2'd1: begin
                w_mul_x = w_ma[26:0];
                w_mul_y = {1'b0, w_mb[52:27]};
            end
            2'd2: begin
                w_mul_x = {1'b0, w_ma[52:27]};
                w_mul_y = w_mb[26:0];
            end
            2'd3: begin
                w_mul_x = {1'b0, w_ma[52:27]};
                w_mul_y = {1'b0, w_mb[52:27]};
            end
            default: begin
                w_mul_x = w_ma[26:0];
                w_mul_y = w_mb[26:0];
            end
        endcase
        w_pp = 54'(w_mul_x) * 54'(w_mul_y);
        case (i_cmd.k)
            2'd0:    w_mul_term = 106'(w_pp);
            2'd1:    w_mul_term = 106'(w_pp) << 27;
            2'd2:    w_mul_term = 106'(w_pp) << 27;
            2'd3:    w_mul_term = 106'(w_pp) << 54;
            default: w_mul_term = 106'(w_pp);
        endcase
    end

    always_comb begin
        w_pexp = {2'b00, w_elem[62:52]} + {2'b00, w_vec[62:52]} - EXP_BIAS;
        if (r_mul_acc[105]) begin
            w_prod_bits = rne_pack(r_mul_acc[105:53], r_mul_acc[52], |r_mul_acc[51:0],
                                   w_pexp + 13'd1);
        end else begin
            w_prod_bits = rne_pack(r_mul_acc[104:52], r_mul_acc[51], |r_mul_acc[50:0],
                                   w_pexp);
        end
    end

    // Adder align
    always_comb begin
        w_x_inf  = (r_acc[62:52] == EXP_ALL);
        w_y_inf  = (r_prod[62:52] == EXP_ALL);
        w_x_zero = (r_acc[62:0] == 63'd0);
        w_x_ge   = (r_acc[62:0] >= r_prod[62:0]);
        w_big    = w_x_ge ? r_acc : r_prod;
        w_sml    = w_x_ge ? r_prod : r_acc;
        w_d      = w_big[62:52] - w_sml[62:52];
        w_sml_ext = {1'b1, w_sml[51:0], 3'b000};
        w_shift  = '0;
        w_mask   = '0;
        w_sticky = 1'b1;
        if (w_d < 11'd56) begin
            w_shift  = w_sml_ext >> w_d;
            w_mask   = (56'd1 << w_d) - 56'd1;
            w_sticky = |(w_sml_ext & w_mask);
        end
        w_align = w_shift | 56'(w_sticky);
    end

    assign w_sum = 57'(r_big_m) + 57'(r_small);

    always_comb begin
        n_acc = r_acc;
        if (i_cmd.add_rnd) begin
            if (r_pass) begin
                n_acc = r_pass_bits;
            end else begin
                n_acc = rne_pack(r_sum_m[55:3], r_sum_m[2], r_sum_m[1] | r_sum_m[0],
                                 {1'b0, r_sum_e});
            end
        end
        if (i_cmd.acc_clear) begin
            n_acc = DBL_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold <= '0;
            r_lcg  <= '0;
            r_acc  <= DBL_ZERO;
        end else begin
            r_fold <= n_fold;
            r_lcg  <= n_lcg;
            r_acc  <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lcg_en) begin
            r_lcg_acc <= (i_cmd.k == 2'd0) ? w_lcg_term : r_lcg_acc + w_lcg_term;
        end
        if (i_cmd.mul_en) begin
            r_mul_acc <= (i_cmd.k == 2'd0) ? w_mul_term : r_mul_acc + w_mul_term;
        end
        if (i_cmd.mul_rnd) begin
            r_prod <= w_prod_bits;
        end
        if (i_cmd.add_align) begin
            r_pass      <= w_x_inf || w_y_inf || w_x_zero;
            r_pass_bits <= (w_x_inf || w_y_inf) ? DBL_INF : r_prod;
            r_big_m     <= {1'b1, w_big[51:0], 3'b000};
            r_small     <= w_align;
            r_big_e     <= {1'b0, w_big[62:52]};
        end
        if (i_cmd.add_sum) begin
            if (w_sum[56]) begin
                r_sum_m <= {w_sum[56:2], w_sum[1] | w_sum[0]};
                r_sum_e <= r_big_e + 12'd1;
            end else begin
                r_sum_m <= w_sum[55:0];
                r_sum_e <= r_big_e;
            end
        end
    end

    assign o_acc_bits = r_acc;

endmodule

[design/sdmvp_ctrl.sv]
// Controller: sequences vector fill, per-element multiply-add and row output.
`include "seeded_double_matrix_vector_product_defines.svh"
module sdmvp_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_seed_last,
    output logic                        o_busy,
    output sdmvp_pkg::t_cmd             o_cmd,
    output logic                        o_strobe,
    output logic [sdmvp_pkg::IDX_W-1:0] o_row,
    output logic                        o_row_last
);
    import sdmvp_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DIM - 1);

    t_state           r_state, n_state;
    logic [1:0]       r_k, n_k;
    logic [IDX_W-1:0] r_col, n_col;
    logic [IDX_W-1:0] r_row, n_row;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_col   = r_col;
        n_row   = r_row;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_seed_last) begin
                    n_state = S_VLCG;
                    n_k     = 2'd0;
                    n_col   = '0;
                    n_row   = '0;
                end
            end
            S_VLCG: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_VWR;
                end
            end
            S_VWR: begin
                if (r_col == LAST_IDX) begin
                    n_col   = '0;
                    n_state = S_MLCG;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_VLCG;
                end
            end
            S_MLCG: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_MMUL;
                end
            end
            S_MMUL: begin
                n_k = r_k + 2'd1;
                if (r_k == 2'd3) begin
                    n_state = S_MRND;
                end
            end
            S_MRND:   n_state = S_AALIGN;
            S_AALIGN: n_state = S_ASUM;
            S_ASUM:   n_state = S_ARND;
            S_ARND: begin
                if (r_col == LAST_IDX) begin
                    n_col   = '0;
                    n_state = S_EMIT;
                end else begin
                    n_col   = r_col + 1'b1;
                    n_state = S_MLCG;
                end
            end
            S_EMIT: begin
                if (r_row == LAST_IDX) begin
                    n_row   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_row   = r_row + 1'b1;
                    n_state = S_MLCG;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.k          = r_k;
        o_cmd.addr       = r_col;
        case (r_state)
            S_IDLE: begin
                o_cmd.fold_en   = i_start;
                o_cmd.fold_load = i_start && i_seed_last;
            end
            S_VLCG:   o_cmd.lcg_en = 1'b1;
            S_VWR: begin
                o_cmd.vec_wr     = 1'b1;
                o_cmd.lcg_reload = (r_col == LAST_IDX);
            end
            S_MLCG: begin
                o_cmd.lcg_en = 1'b1;
                o_cmd.vec_rd = (r_k == 2'd0);
            end
            S_MMUL:   o_cmd.mul_en    = 1'b1;
            S_MRND:   o_cmd.mul_rnd   = 1'b1;
            S_AALIGN: o_cmd.add_align = 1'b1;
            S_ASUM:   o_cmd.add_sum   = 1'b1;
            S_ARND:   o_cmd.add_rnd   = 1'b1;
            S_EMIT: begin
                o_cmd.acc_clear  = 1'b1;
                o_cmd.fold_clear = (r_row == LAST_IDX);
            end
            default: o_cmd.k = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

    assign o_busy     = (r_state != S_IDLE);
    assign o_strobe   = (r_state == S_EMIT);
    assign o_row      = r_row;
    assign o_row_last = (r_row == LAST_IDX);

    `SDMVP_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_strobe, !o_strobe, "strobe held")
    `SDMVP_ASSERT_NEXT(a_last_row_ends, i_clk, i_rst_n, o_strobe && o_row_last,
                       r_state == S_IDLE, "run did not end after last row")
    `SDMVP_ASSERT_NEXT(a_last_byte_starts, i_clk, i_rst_n, i_start && !o_busy && i_seed_last,
                       o_busy, "last byte did not start a run")
    `SDMVP_ASSERT_NOW(a_rows_in_order, i_clk, i_rst_n, r_state == S_VLCG || r_state == S_VWR,
                      r_row == '0, "row counter moved during vector fill")

endmodule

[design/seeded_double_matrix_vector_product.sv]
// Top level of the seeded double matrix-vector product.
//
//  channel | ports                     | transaction
//  --------+---------------------------+---------------------------------
//  input   | start, busy, i_item       | start high while busy low
//  result  | o_strobe, o_result        | one cycle with o_strobe high
//
// A seed byte without the last mark is folded into the seed. The last byte starts a run:
// the vector RAM is filled first (an LCG step in four chunks plus a write per element),
// then each of the 4096 matrix elements goes through an LCG step, a partial-product
// multiply, a round and an add (align, sum, round), plus an output state per row.
// busy stays high for the whole run. Reset is synchronous; results cannot stall.
module seeded_double_matrix_vector_product (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  sdmvp_pkg::t_in   i_item,
    output logic             busy,
    output logic             o_strobe,
    output sdmvp_pkg::t_out  o_result
);
    import sdmvp_pkg::*;

    t_cmd             w_cmd;
    logic [63:0]      w_acc;
    logic [IDX_W-1:0] w_row;
    logic             w_row_last;

    sdmvp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_seed_last (i_item.seed_last),
        .o_busy      (busy),
        .o_cmd       (w_cmd),
        .o_strobe    (o_strobe),
        .o_row       (w_row),
        .o_row_last  (w_row_last)
    );

    sdmvp_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_seed_byte (i_item.seed_byte),
        .o_acc_bits  (w_acc)
    );

    always_comb begin
        o_result.row_sum_bits = w_acc;
        o_result.row_index    = ROW_INDEX_W'(w_row);
        o_result.row_last     = w_row_last;
    end

endmodule
